// ----- rtl/core/stiffness_ramp_calibrator_defines.svh -----
// ------------------------------------------------------------------------
// Stiffness ramp calibrator assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i with reset off.
// ------------------------------------------------------------------------
`ifndef STIFFNESS_RAMP_CALIBRATOR_DEFINES_SVH
`define STIFFNESS_RAMP_CALIBRATOR_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define SRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication checked on the following edge.
`define SRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/src_pkg.sv -----
// ------------------------------------------------------------------------
// Stiffness ramp calibrator package
// Phase codes, sequencer states, register indexes and operation codes.
// ------------------------------------------------------------------------
package src_pkg;

  typedef enum logic [2:0] {
    PH_BLOCKED = 3'd0,
    PH_RAMP    = 3'd1,
    PH_HOLD    = 3'd2,
    PH_WAIT    = 3'd3,
    PH_DONE    = 3'd4
  } phase_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_PX, ST_PY, ST_FX, ST_FY, ST_RATE, ST_XY, ST_XX,
    ST_RAMP_END, ST_NSXY, ST_SXSY, ST_NSXX, ST_SXSX, ST_DIV, ST_TICK,
    ST_CX, ST_CY, ST_OUT
  } step_e;

  localparam logic [1:0] CFG_RAMP_RATE  = 2'd0;
  localparam logic [1:0] CFG_HOLD_TICKS = 2'd1;
  localparam logic [1:0] CFG_WAIT_TICKS = 2'd2;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

endpackage

// ----- rtl/core/stiffness_ramp_calibrator.sv -----
// ------------------------------------------------------------------------
// Stiffness ramp calibrator
// Ramps a force along each heading, fits stiffness by least squares.
// ------------------------------------------------------------------------
// Every product goes through one shared bit-serial multiplier. A ramp tick needs up
// to nine products; a tick that ends a hold with two or more samples adds four
// products and, if the denominator is positive, a bit-serial divide.
// One transfer is worked on at a time; the next is taken once the result is in
// the output register. Reset: phase blocked, heading, ticks, sums and counts zero,
// registers 64, 100 and 100; no clearing pass.
module stiffness_ramp_calibrator
  import src_pkg::*;
#(
  parameter int NUM_HEADINGS = 8,
  parameter int MAX_SAMPLES  = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Configuration write port.
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  // Input stream.
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // From bit 0: boundary_known, pos_x, pos_y, force_x, force_y, dir_cos, dir_sin,
  // boundary_radius, force_limit, zero fill.
  input  logic [135:0]  s_axis_tdata,
  // operation.
  input  logic          s_axis_tuser,
  // Result stream.
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // From bit 0: phase, heading_index, command_x, command_y, command_magnitude,
  // fit_ready, stiffness, fit_valid, sample_total, zero fill.
  output logic [((93 + $clog2(MAX_SAMPLES + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  `include "stiffness_ramp_calibrator_defines.svh"

  // Widths that follow from the sample limit.
  localparam int CntW  = $clog2(MAX_SAMPLES + 1);
  localparam int SumW  = 17 + CntW;
  localparam int SqW   = 34 + CntW;
  localparam int MulAW = 34 + CntW;
  localparam int MulBW = 18 + CntW;
  localparam int ProdW = MulAW + MulBW;
  localparam int NumW  = 36 + 2 * CntW;
  localparam int DivW  = NumW + 8;
  localparam int OutW  = 93 + CntW;
  localparam int OutPW = ((OutW + 7) / 8) * 8;
  localparam int McW   = $clog2(MulBW + 1);
  localparam int DcW   = $clog2(DivW);

  // Configuration registers.
  logic [15:0] ramp_rate_q, hold_ticks_q, wait_ticks_q;

  // Latched input transfer.
  logic               op_q, bk_q;
  logic signed [15:0] px_q, py_q, fx_q, fy_q, cos_q, sin_q;
  logic [15:0]        rad_q, lim_q;

  // Architectural state.
  phase_e                  phase_q, phase_d;
  logic [5:0]              heading_q, heading_d;
  logic [15:0]             ticks_q, ticks_d, peak_q, peak_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic signed [SumW-1:0]  sx_q, sx_d, sy_q, sy_d;
  logic signed [SqW-1:0]   sxy_q, sxy_d, sxx_q, sxx_d;

  // Per-transfer working registers.
  step_e                   step_q, step_d;
  logic signed [33:0]      acc_q, acc_d, pxy_q, pxy_d;
  logic signed [16:0]      x_q, x_d, y_q, y_d, cx_q, cx_d, cy_q, cy_d;
  logic [15:0]             mag_q, mag_d;
  logic                    moved_q, moved_d, ready_q, ready_d, valid_q, valid_d;
  logic [31:0]             stiff_q, stiff_d;
  logic signed [NumW-1:0]  num_q, num_d, den_q, den_d;

  // Divider.
  logic [DivW-1:0] ds_q, ds_d;
  logic [NumW:0]   rem_q, rem_d;
  logic [30:0]     quo_q, quo_d;
  logic            over_q, over_d, dneg_q, dneg_d;
  logic [DcW-1:0]  dcnt_q, dcnt_d;

  // Shared bit-serial multiplier.
  logic                    mul_start, issued_q, issued_d;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic [MulAW-1:0]        abs_a;
  logic [MulBW-1:0]        abs_b;
  logic [ProdW-1:0]        ma_q, macc_q;
  logic [MulBW-1:0]        mb_q;
  logic                    mneg_q, mbusy_q, mdone_q;
  logic [McW-1:0]          mcnt_q;
  logic signed [ProdW-1:0] prod;

  // Output register.
  logic             m_valid_q, out_load;
  logic [OutPW-1:0] m_data_q, out_word;

  // Combinational helpers.
  logic signed [33:0]     tot;
  logic signed [19:0]     rnd;
  logic signed [16:0]     proj;
  logic signed [33:0]     cmd_sum;
  logic [31:0]            want;
  logic [15:0]            mag_new;
  logic signed [NumW-1:0] den_new, num_abs;
  logic [NumW:0]          rem_sh;
  logic                   qbit;
  logic [30:0]            quo_new;
  logic                   over_new;
  logic [6:0]             head_next;

  assign s_axis_tready = (step_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // ----- configuration -----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_rate_q  <= 16'd64;
      hold_ticks_q <= 16'd100;
      wait_ticks_q <= 16'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RAMP_RATE:  ramp_rate_q  <= cfg_data_i;
        CFG_HOLD_TICKS: hold_ticks_q <= cfg_data_i;
        CFG_WAIT_TICKS: wait_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ----- input capture -----
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q  <= s_axis_tuser;
      bk_q  <= s_axis_tdata[0];
      px_q  <= s_axis_tdata[16:1];
      py_q  <= s_axis_tdata[32:17];
      fx_q  <= s_axis_tdata[48:33];
      fy_q  <= s_axis_tdata[64:49];
      cos_q <= s_axis_tdata[80:65];
      sin_q <= s_axis_tdata[96:81];
      rad_q <= s_axis_tdata[112:97];
      lim_q <= s_axis_tdata[128:113];
    end
  end

  // ----- bit-serial multiplier: sign and magnitude, one multiplier bit a cycle -----
  assign abs_a = mul_a[MulAW-1] ? MulAW'(-mul_a) : MulAW'(mul_a);
  assign abs_b = mul_b[MulBW-1] ? MulBW'(-mul_b) : MulBW'(mul_b);
  assign prod  = mneg_q ? -$signed(macc_q) : $signed(macc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
      mdone_q <= 1'b0;
      mcnt_q  <= '0;
    end else begin
      mdone_q <= mbusy_q && (mcnt_q == McW'(1));
      if (mul_start) begin
        mbusy_q <= 1'b1;
        mcnt_q  <= McW'(MulBW);
      end else if (mbusy_q) begin
        mcnt_q <= mcnt_q - McW'(1);
        if (mcnt_q == McW'(1)) mbusy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_start) begin
      ma_q   <= ProdW'(abs_a);
      mb_q   <= abs_b;
      macc_q <= '0;
      mneg_q <= mul_a[MulAW-1] ^ mul_b[MulBW-1];
    end else if (mbusy_q) begin
      if (mb_q[0]) macc_q <= macc_q + ma_q;
      ma_q <= ma_q << 1;
      mb_q <= mb_q >> 1;
    end
  end

  // ----- helpers -----
  // Round half up of a divide by 2^14, then saturate to the signed 17-bit Q17.0 range.
  assign tot  = acc_q + prod[33:0];
  assign rnd  = 20'((tot + 34'sd8192) >>> 14);
  assign proj = (rnd > 20'sd65535) ? 17'sd65535 :
                (rnd < -20'sd65536) ? -17'sd65536 : rnd[16:0];
  // The command product may be negative, so the shift must keep the sign.
  assign cmd_sum = 34'(($signed(prod[33:0]) + 34'sd8192) >>> 14);

  assign want    = prod[31:0];
  assign mag_new = (want < {16'd0, lim_q}) ? want[15:0] : lim_q;
  assign den_new = den_q - prod[NumW-1:0];
  assign num_abs = num_q[NumW-1] ? -num_q : num_q;

  assign rem_sh   = {rem_q[NumW-1:0], ds_q[DivW-1]};
  assign qbit     = (rem_sh >= {1'b0, den_q});
  assign quo_new  = {quo_q[29:0], qbit};
  assign over_new = over_q | (qbit && (dcnt_q >= DcW'(31)));
  assign head_next = {1'b0, heading_q} + 7'd1;

  // ----- sequencer -----
  always_comb begin
    step_d    = step_q;
    phase_d   = phase_q;
    heading_d = heading_q;
    ticks_d   = ticks_q;
    peak_d    = peak_q;
    cnt_d     = cnt_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    sxy_d     = sxy_q;
    sxx_d     = sxx_q;
    acc_d     = acc_q;
    pxy_d     = pxy_q;
    x_d       = x_q;
    y_d       = y_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    mag_d     = mag_q;
    moved_d   = moved_q;
    ready_d   = ready_q;
    valid_d   = valid_q;
    stiff_d   = stiff_q;
    num_d     = num_q;
    den_d     = den_q;
    ds_d      = ds_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    over_d    = over_q;
    dneg_d    = dneg_q;
    dcnt_d    = dcnt_q;
    issued_d  = issued_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    out_load  = 1'b0;

    // Operand selection for the states that multiply.
    unique case (step_q)
      ST_PX:   begin mul_a = MulAW'(px_q);  mul_b = MulBW'(cos_q); end
      ST_PY:   begin mul_a = MulAW'(py_q);  mul_b = MulBW'(sin_q); end
      ST_FX:   begin mul_a = MulAW'(fx_q);  mul_b = MulBW'(cos_q); end
      ST_FY:   begin mul_a = MulAW'(fy_q);  mul_b = MulBW'(sin_q); end
      ST_RATE: begin
        mul_a = MulAW'({1'b0, ramp_rate_q});
        mul_b = MulBW'({1'b0, ticks_q});
      end
      ST_XY:   begin mul_a = MulAW'(x_q);   mul_b = MulBW'(y_q); end
      ST_XX:   begin mul_a = MulAW'(x_q);   mul_b = MulBW'(x_q); end
      ST_NSXY: begin mul_a = MulAW'(sxy_q); mul_b = MulBW'({1'b0, cnt_q}); end
      ST_SXSY: begin mul_a = MulAW'(sx_q);  mul_b = MulBW'(sy_q); end
      ST_NSXX: begin mul_a = MulAW'(sxx_q); mul_b = MulBW'({1'b0, cnt_q}); end
      ST_SXSX: begin mul_a = MulAW'(sx_q);  mul_b = MulBW'(sx_q); end
      ST_CX:   begin mul_a = MulAW'({1'b0, mag_q}); mul_b = MulBW'(cos_q); end
      ST_CY:   begin mul_a = MulAW'({1'b0, mag_q}); mul_b = MulBW'(sin_q); end
      default: ;
    endcase

    unique case (step_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          ready_d = 1'b0;
          valid_d = 1'b0;
          stiff_d = '0;
          moved_d = 1'b0;
          step_d  = ST_DECODE;
        end
      end

      ST_DECODE: begin
        mag_d = '0;
        if (op_q == OP_START) begin
          if (bk_q) begin
            phase_d   = PH_RAMP;
            heading_d = '0;
            ticks_d   = '0;
            peak_d    = '0;
            cnt_d     = '0;
            sx_d      = '0;
            sy_d      = '0;
            sxy_d     = '0;
            sxx_d     = '0;
          end else begin
            phase_d = PH_BLOCKED;
          end
          step_d = ST_CX;
        end else begin
          unique case (phase_q)
            PH_RAMP: step_d = ST_PX;
            PH_HOLD: begin
              mag_d  = peak_q;
              step_d = ST_TICK;
              if (ticks_q >= hold_ticks_q) begin
                ready_d = 1'b1;
                mag_d   = '0;
                phase_d = PH_WAIT;
                moved_d = 1'b1;
                if (cnt_q >= CntW'(2)) step_d = ST_NSXY;
              end
            end
            PH_WAIT: begin
              step_d = ST_TICK;
              if (ticks_q >= wait_ticks_q) begin
                moved_d = 1'b1;
                if (head_next < 7'(NUM_HEADINGS)) begin
                  heading_d = head_next[5:0];
                  phase_d   = PH_RAMP;
                  peak_d    = '0;
                  cnt_d     = '0;
                  sx_d      = '0;
                  sy_d      = '0;
                  sxy_d     = '0;
                  sxx_d     = '0;
                end else begin
                  phase_d = PH_DONE;
                end
              end
            end
            default: step_d = ST_CX;
          endcase
        end
      end

      ST_PX, ST_PY, ST_FX, ST_FY, ST_RATE, ST_XY, ST_XX,
      ST_NSXY, ST_SXSY, ST_NSXX, ST_SXSX, ST_CX, ST_CY: begin
        if (mdone_q) begin
          issued_d = 1'b0;
          case (step_q)
            ST_PX: begin acc_d = prod[33:0]; step_d = ST_PY; end
            ST_PY: begin x_d = proj; step_d = ST_FX; end
            ST_FX: begin acc_d = prod[33:0]; step_d = ST_FY; end
            ST_FY: begin y_d = proj; step_d = ST_RATE; end
            ST_RATE: begin
              mag_d  = mag_new;
              step_d = (cnt_q < CntW'(MAX_SAMPLES)) ? ST_XY : ST_RAMP_END;
            end
            ST_XY: begin pxy_d = prod[33:0]; step_d = ST_XX; end
            ST_XX: begin
              cnt_d  = cnt_q + CntW'(1);
              sx_d   = sx_q + SumW'(x_q);
              sy_d   = sy_q + SumW'(y_q);
              sxy_d  = sxy_q + SqW'(pxy_q);
              sxx_d  = sxx_q + SqW'(prod[33:0]);
              step_d = ST_RAMP_END;
            end
            ST_NSXY: begin num_d = prod[NumW-1:0]; step_d = ST_SXSY; end
            ST_SXSY: begin num_d = num_q - prod[NumW-1:0]; step_d = ST_NSXX; end
            ST_NSXX: begin den_d = prod[NumW-1:0]; step_d = ST_SXSX; end
            ST_SXSX: begin
              if (den_new <= 0) begin
                step_d = ST_TICK;
              end else begin
                den_d  = den_new;
                dneg_d = num_q[NumW-1];
                ds_d   = {num_abs, 8'd0};
                rem_d  = '0;
                quo_d  = '0;
                over_d = 1'b0;
                dcnt_d = DcW'(DivW - 1);
                step_d = ST_DIV;
              end
            end
            ST_CX: begin cx_d = cmd_sum[16:0]; step_d = ST_CY; end
            ST_CY: begin cy_d = cmd_sum[16:0]; step_d = ST_OUT; end
            default: ;
          endcase
        end else if (!issued_q) begin
          mul_start = 1'b1;
          issued_d  = 1'b1;
        end
      end

      ST_RAMP_END: begin
        if (($signed({x_q[16], x_q}) >= $signed({2'b00, rad_q})) || (mag_q >= lim_q)) begin
          peak_d  = mag_q;
          phase_d = PH_HOLD;
          moved_d = 1'b1;
        end
        step_d = ST_TICK;
      end

      // Restoring divide, one quotient bit a cycle, most significant first.
      ST_DIV: begin
        rem_d  = qbit ? (rem_sh - {1'b0, den_q}) : rem_sh;
        ds_d   = ds_q << 1;
        quo_d  = quo_new;
        over_d = over_new;
        dcnt_d = dcnt_q - DcW'(1);
        if (dcnt_q == '0) begin
          valid_d = 1'b1;
          if (over_new) stiff_d = dneg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
          else          stiff_d = dneg_q ? -{1'b0, quo_new} : {1'b0, quo_new};
          step_d = ST_TICK;
        end
      end

      ST_TICK: begin
        if (phase_q != PH_BLOCKED && phase_q != PH_DONE) begin
          if (moved_q)                ticks_d = 16'd1;
          else if (ticks_q != 16'hFFFF) ticks_d = ticks_q + 16'd1;
        end
        step_d = ST_CX;
      end

      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          step_d   = ST_IDLE;
        end
      end

      default: step_d = ST_IDLE;
    endcase
  end

  assign out_word = OutPW'({cnt_q, valid_q, stiff_q, ready_q, mag_q, cy_q, cx_q,
                            heading_q, phase_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= ST_IDLE;
      phase_q   <= PH_BLOCKED;
      heading_q <= '0;
      ticks_q   <= '0;
      peak_q    <= '0;
      cnt_q     <= '0;
      sx_q      <= '0;
      sy_q      <= '0;
      sxy_q     <= '0;
      sxx_q     <= '0;
      issued_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      step_q    <= step_d;
      phase_q   <= phase_d;
      heading_q <= heading_d;
      ticks_q   <= ticks_d;
      peak_q    <= peak_d;
      cnt_q     <= cnt_d;
      sx_q      <= sx_d;
      sy_q      <= sy_d;
      sxy_q     <= sxy_d;
      sxx_q     <= sxx_d;
      issued_q  <= issued_d;
      if (out_load)           m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    pxy_q   <= pxy_d;
    x_q     <= x_d;
    y_q     <= y_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    mag_q   <= mag_d;
    moved_q <= moved_d;
    ready_q <= ready_d;
    valid_q <= valid_d;
    stiff_q <= stiff_d;
    num_q   <= num_d;
    den_q   <= den_d;
    ds_q    <= ds_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    over_q  <= over_d;
    dneg_q  <= dneg_d;
    dcnt_q  <= dcnt_d;
    if (out_load) m_data_q <= out_word;
  end

  // ----- assertions -----
  `SRC_ASSERT(a_cnt_limit, cnt_q <= CntW'(MAX_SAMPLES), "sample count beyond limit")
  `SRC_ASSERT(a_mul_owner, !mbusy_q || issued_q, "multiplier running without an owner")
  `SRC_ASSERT_NEXT(a_accept_leaves_idle, s_axis_tvalid && s_axis_tready, step_q == ST_DECODE,
                   "accepted transfer not decoded")
  `SRC_ASSERT(a_valid_needs_ready, !(m_valid_q && m_data_q[92] && !m_data_q[59]),
              "fit valid without fit ready")

endmodule
